/* src/letter_frequency_histogram_assert.svh */
// assertion helpers for the letter histogram
`ifndef LETTER_FREQUENCY_HISTOGRAM_ASSERT_SVH
`define LETTER_FREQUENCY_HISTOGRAM_ASSERT_SVH

// a property that must hold at every edge outside reset
`define LFH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// a condition that must be followed by another in the next cycle
`define LFH_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/lfh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfh_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BINS    = 26;
    localparam int BIN_IDX_W   = 5;
    localparam int OUT_W       = 32;
    localparam int SKIP_W      = 16;
    localparam int PERIOD_W    = 8;
    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;

    localparam logic REQ_FEED = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic REG_SKIP   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef struct packed {
        logic                 inc;
        logic [BIN_IDX_W-1:0] addr;
    } t_bin_cmd;

endpackage

`default_nettype wire

/* src/lfh_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lfh_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [lfh_pkg::BYTE_W-1:0]    text_byte;
    logic [lfh_pkg::BIN_IDX_W-1:0] bin_index;

    modport source (output valid, req_type, text_byte, bin_index, input ready);
    modport sink (input valid, req_type, text_byte, bin_index, output ready);
endinterface

interface lfh_out_if;
    logic                     valid;
    logic                     ready;
    logic [lfh_pkg::OUT_W-1:0] bin_count;
    logic [lfh_pkg::OUT_W-1:0] total_counted;
    logic                     was_counted;

    modport source (output valid, bin_count, total_counted, was_counted, input ready);
    modport sink (input valid, bin_count, total_counted, was_counted, output ready);
endinterface

`default_nettype wire

/* src/lfh_bins.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfh_bins (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lfh_pkg::t_bin_cmd         i_cmd,
    output logic [lfh_pkg::OUT_W-1:0]      o_bin_count,
    output logic [lfh_pkg::OUT_W-1:0]      o_total_next
);

    localparam int CW = lfh_pkg::COUNT_WIDTH;

    logic [CW-1:0] r_bins [lfh_pkg::NUM_BINS];
    logic [CW-1:0] r_total;
    logic [CW-1:0] n_total;
    logic [CW-1:0] bin_cur;
    logic [CW-1:0] bin_inc;
    logic          in_range;
    logic [CW+lfh_pkg::OUT_W-1:0] bin_ext;
    logic [CW+lfh_pkg::OUT_W-1:0] total_ext;

    assign in_range = i_cmd.addr < lfh_pkg::BIN_IDX_W'(lfh_pkg::NUM_BINS);
    assign bin_cur  = in_range ? r_bins[i_cmd.addr] : '0;
    // saturating increments
    assign bin_inc  = (bin_cur == {CW{1'b1}}) ? bin_cur : bin_cur + CW'(1);
    assign n_total  = !i_cmd.inc ? r_total :
                      (r_total == {CW{1'b1}}) ? r_total : r_total + CW'(1);

    // outputs carry the low bits of the counts
    assign bin_ext      = {{lfh_pkg::OUT_W{1'b0}}, bin_cur};
    assign total_ext    = {{lfh_pkg::OUT_W{1'b0}}, n_total};
    assign o_bin_count  = bin_ext[lfh_pkg::OUT_W-1:0];
    assign o_total_next = total_ext[lfh_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lfh_pkg::NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
            r_total <= '0;
        end else begin
            r_total <= n_total;
            if (i_cmd.inc && in_range) begin
                r_bins[i_cmd.addr] <= bin_inc;
            end
        end
    end

endmodule

`default_nettype wire

/* src/letter_frequency_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel    dir  handshake       payload
// i_item     in   valid/ready     req_type, text_byte, bin_index
// o_result   out  valid/ready     bin_count, total_counted, was_counted
// apb        in   psel/penable    skip_letters @0x0, letter_period @0x4
//
// one item per cycle while the result is not stalled; the result is in the output register the cycle after accept
// the bin read and saturating increment happen in the accept cycle
// ready stays high while the output register is empty or being taken
// reset clears all bins, the total and the skip/stride counters
// a stalled result holds the output register and blocks new items only then

module letter_frequency_histogram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lfh_in_if.sink                           i_item,
    lfh_out_if.source                        o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lfh_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lfh_pkg::DATA_W-1:0]  pwdata,
    output logic [lfh_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    `include "letter_frequency_histogram_assert.svh"

    logic [lfh_pkg::SKIP_W-1:0]   r_skip;
    logic [lfh_pkg::PERIOD_W-1:0] r_period;
    logic [lfh_pkg::SKIP_W-1:0]   r_skipped;
    logic [lfh_pkg::PERIOD_W-1:0] r_phase;

    logic                         r_valid;
    logic [lfh_pkg::OUT_W-1:0]    r_bin_count;
    logic [lfh_pkg::OUT_W-1:0]    r_total;
    logic                         r_counted;

    logic                         accept;
    logic                         cfg_wr;
    logic [lfh_pkg::PERIOD_W-1:0] wr_period;
    logic                         is_upper;
    logic                         is_lower;
    logic                         is_letter;
    logic [lfh_pkg::BIN_IDX_W-1:0] letter_idx;
    logic                         do_skip;
    logic                         do_phase;
    logic                         do_count;
    lfh_pkg::t_bin_cmd            bin_cmd;
    logic [lfh_pkg::OUT_W-1:0]    bin_count;
    logic [lfh_pkg::OUT_W-1:0]    total_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            lfh_pkg::REG_SKIP:
                prdata = {{(lfh_pkg::DATA_W - lfh_pkg::SKIP_W){1'b0}}, r_skip};
            lfh_pkg::REG_PERIOD:
                prdata = {{(lfh_pkg::DATA_W - lfh_pkg::PERIOD_W){1'b0}}, r_period};
            default: prdata = '0;
        endcase
    end

    // a written zero period means count every letter
    assign wr_period = (pwdata[lfh_pkg::PERIOD_W-1:0] == '0) ? lfh_pkg::PERIOD_W'(1)
                                                              : pwdata[lfh_pkg::PERIOD_W-1:0];

    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign is_upper  = i_item.text_byte inside {[lfh_pkg::UPPER_A:lfh_pkg::UPPER_Z]};
    assign is_lower  = i_item.text_byte inside {[lfh_pkg::LOWER_A:lfh_pkg::LOWER_Z]};
    assign is_letter = (i_item.req_type == lfh_pkg::REQ_FEED) && (is_upper || is_lower);
    // both cases carry A..Z as 1..26 in the low five bits
    assign letter_idx = i_item.text_byte[lfh_pkg::BIN_IDX_W-1:0] - lfh_pkg::BIN_IDX_W'(1);

    assign do_skip  = accept && is_letter && (r_skipped < r_skip);
    assign do_phase = accept && is_letter && !(r_skipped < r_skip)
                      && (r_phase < r_period - lfh_pkg::PERIOD_W'(1));
    assign do_count = accept && is_letter && !(r_skipped < r_skip) && !do_phase;

    assign bin_cmd.inc  = do_count;
    assign bin_cmd.addr = (i_item.req_type == lfh_pkg::REQ_READ) ? i_item.bin_index
                                                                 : letter_idx;

    lfh_bins u_bins (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (bin_cmd),
        .o_bin_count  (bin_count),
        .o_total_next (total_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip    <= '0;
            r_period  <= lfh_pkg::PERIOD_W'(1);
            r_skipped <= '0;
            r_phase   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    lfh_pkg::REG_SKIP: begin
                        r_skip <= pwdata[lfh_pkg::SKIP_W-1:0];
                    end
                    lfh_pkg::REG_PERIOD: begin
                        r_period <= wr_period;
                        r_phase  <= wr_period - lfh_pkg::PERIOD_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            if (do_skip) begin
                r_skipped <= r_skipped + lfh_pkg::SKIP_W'(1);
            end
            if (do_phase) begin
                r_phase <= r_phase + lfh_pkg::PERIOD_W'(1);
            end else if (do_count) begin
                r_phase <= '0;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin_count <= (i_item.req_type == lfh_pkg::REQ_READ) ? bin_count : '0;
            r_total     <= total_next;
            r_counted   <= do_count;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.bin_count     = r_bin_count;
    assign o_result.total_counted = r_total;
    assign o_result.was_counted   = r_counted;

    `LFH_ASSERT(a_counted_total, (r_valid && r_counted) |-> (r_total != '0), "counted item with zero total")
    `LFH_ASSERT(a_phase_range, (r_period != '0) && (r_phase < r_period), "stride phase out of range")
    `LFH_ASSERT_NEXT(a_read_not_counted, accept && (i_item.req_type == lfh_pkg::REQ_READ), !r_counted, "read item marked counted")
    `LFH_ASSERT_NEXT(a_feed_no_bin, accept && (i_item.req_type == lfh_pkg::REQ_FEED), r_bin_count == '0, "feed item with bin count")

endmodule

`default_nettype wire

/* tb/histogram_checker.sv */
`timescale 1ns / 1ps

module histogram_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [lfh_pkg::BYTE_W-1:0]    i_text_byte,
    input  wire logic [lfh_pkg::BIN_IDX_W-1:0] i_bin_index,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [lfh_pkg::OUT_W-1:0]     i_bin_count,
    input  wire logic [lfh_pkg::OUT_W-1:0]     i_total_counted,
    input  wire logic                          i_was_counted,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [lfh_pkg::ADDR_W-1:0]    i_paddr,
    input  wire logic [lfh_pkg::DATA_W-1:0]    i_pwdata,
    output int                                 o_errors,
    output int                                 o_outstanding
);
    import lfh_pkg::*;

    localparam logic [ADDR_W-1:0]      ADDR_SKIP   = {REG_SKIP, 2'b00};
    localparam logic [ADDR_W-1:0]      ADDR_PERIOD = {REG_PERIOD, 2'b00};
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP   = '1;

    typedef struct packed {
        logic [OUT_W-1:0] bin_count;
        logic [OUT_W-1:0] total_counted;
        logic             was_counted;
    } t_hist_result;

    logic [COUNT_WIDTH-1:0] letter_count [NUM_BINS];
    logic [COUNT_WIDTH-1:0] letters_total;
    logic [SKIP_W-1:0]      letters_skipped;
    logic [SKIP_W-1:0]      skip_cfg;
    logic [PERIOD_W-1:0]    stride_phase;
    logic [PERIOD_W-1:0]    stride_cfg;
    t_hist_result           expected_results [$];
    int                     error_count = 0;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // advances the histogram by one item and returns what the block should answer
    function automatic t_hist_result tally_item(input logic req,
                                                input logic [BYTE_W-1:0] ch,
                                                input logic [BIN_IDX_W-1:0] idx);
        t_hist_result r;
        logic [BYTE_W-1:0] up;
        logic letter;
        r = '0;
        up = ch;
        letter = 1'b0;
        if (req == REQ_READ) begin
            if (idx < NUM_BINS)
                r.bin_count = letter_count[idx][OUT_W-1:0];
        end else begin
            if (ch >= LOWER_A && ch <= LOWER_Z) begin
                up = ch - LOWER_A + UPPER_A;
                letter = 1'b1;
            end else if (ch >= UPPER_A && ch <= UPPER_Z) begin
                letter = 1'b1;
            end
            if (letter) begin
                if (letters_skipped < skip_cfg) begin
                    letters_skipped = letters_skipped + 1'b1;
                end else if (stride_phase < stride_cfg - 1'b1) begin
                    stride_phase = stride_phase + 1'b1;
                end else begin
                    letter_count[up - UPPER_A] = bump(letter_count[up - UPPER_A]);
                    letters_total = bump(letters_total);
                    stride_phase = '0;
                    r.was_counted = 1'b1;
                end
            end
        end
        r.total_counted = letters_total[OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        error_count++;
        if (error_count <= 100)
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_hist_result want;
        logic [PERIOD_W-1:0] p;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BINS; b++)
                letter_count[b] = '0;
            letters_total = '0;
            letters_skipped = '0;
            skip_cfg = '0;
            stride_cfg = 8'd1;
            stride_phase = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 100)
                        $display("%0t result with nothing expected: bin_count %0d total %0d",
                                 $time, i_bin_count, i_total_counted);
                end else begin
                    want = expected_results.pop_front();
                    if (i_bin_count !== want.bin_count)
                        flag_mismatch("bin_count", want.bin_count, i_bin_count);
                    if (i_total_counted !== want.total_counted)
                        flag_mismatch("total_counted", want.total_counted, i_total_counted);
                    if (i_was_counted !== want.was_counted)
                        flag_mismatch("was_counted", want.was_counted, i_was_counted);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(tally_item(i_req_type, i_text_byte, i_bin_index));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_SKIP) begin
                    skip_cfg = i_pwdata[SKIP_W-1:0];
                end else if (i_paddr == ADDR_PERIOD) begin
                    // a zero period is kept as one, and the stride restarts
                    p = i_pwdata[PERIOD_W-1:0];
                    if (p == '0)
                        p = 8'd1;
                    stride_cfg = p;
                    stride_phase = p - 1'b1;
                end
            end
        end
        o_errors <= error_count;
        o_outstanding <= expected_results.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import lfh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int PER_SETTING = 170;
    localparam int SETTINGS_N  = 7;

    localparam logic [ADDR_W-1:0] ADDR_SKIP   = {REG_SKIP, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int cycles        = 0;
    int errors;
    int outstanding;

    lfh_in_if  in_ch ();
    lfh_out_if out_ch ();

    letter_frequency_histogram dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    histogram_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_req_type      (in_ch.req_type),
        .i_text_byte     (in_ch.text_byte),
        .i_bin_index     (in_ch.bin_index),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_bin_count     (out_ch.bin_count),
        .i_total_counted (out_ch.total_counted),
        .i_was_counted   (out_ch.was_counted),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_errors        (errors),
        .o_outstanding   (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin : receiver
        int hold_left;
        int holds_taken;
        hold_left = 0;
        holds_taken = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_taken < hold_requests) begin
                hold_left = LONG_HOLD;
                holds_taken++;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic offer_item(input logic req, input logic [BYTE_W-1:0] ch,
                              input logic [BIN_IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.text_byte <= ch;
        in_ch.bin_index <= idx;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // mostly letters of either case, some bin reads, some other bytes
    task automatic offer_random_item();
        int pick;
        logic [BYTE_W-1:0] ch;
        logic [BIN_IDX_W-1:0] idx;
        pick = $urandom_range(99);
        ch = BYTE_W'($urandom_range(255));
        idx = BIN_IDX_W'($urandom_range(31));
        if (pick < 20) begin
            if ($urandom_range(9) != 0)
                idx = BIN_IDX_W'($urandom_range(NUM_BINS - 1));
            offer_item(REQ_READ, ch, idx);
        end else if (pick < 32) begin
            offer_item(REQ_FEED, ch, idx);
        end else begin
            ch = ($urandom_range(1) == 1) ? LOWER_A : UPPER_A;
            ch = ch + BYTE_W'($urandom_range(NUM_BINS - 1));
            offer_item(REQ_FEED, ch, idx);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        drain();
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SKIP_W-1:0] skip_val;
        logic [PERIOD_W-1:0] period_val;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.req_type  <= REQ_FEED;
        in_ch.text_byte <= '0;
        in_ch.bin_index <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // letter range edges, non-letters around them, high bytes
        offer_item(REQ_FEED, UPPER_A, 5'd0);
        offer_item(REQ_FEED, UPPER_Z, 5'd31);
        offer_item(REQ_FEED, LOWER_A, 5'd0);
        offer_item(REQ_FEED, LOWER_Z, 5'd31);
        offer_item(REQ_FEED, UPPER_A - 1'b1, 5'd0);
        offer_item(REQ_FEED, UPPER_Z + 1'b1, 5'd0);
        offer_item(REQ_FEED, LOWER_A - 1'b1, 5'd0);
        offer_item(REQ_FEED, LOWER_Z + 1'b1, 5'd0);
        offer_item(REQ_FEED, 8'h00, 5'd0);
        offer_item(REQ_FEED, 8'hFF, 5'd0);
        offer_item(REQ_FEED, 8'h80, 5'd0);
        // reads in range and past the last bin
        offer_item(REQ_READ, 8'hFF, 5'd0);
        offer_item(REQ_READ, 8'h00, BIN_IDX_W'(NUM_BINS - 1));
        offer_item(REQ_READ, 8'h00, BIN_IDX_W'(NUM_BINS));
        offer_item(REQ_READ, 8'h00, 5'd31);
        // skip two letters, then count every third
        write_reg(ADDR_SKIP, 32'd2);
        write_reg(ADDR_PERIOD, 32'd3);
        for (int k = 0; k < 8; k++)
            offer_item(REQ_FEED, LOWER_A + BYTE_W'(1 + k), 5'd0);
        offer_item(REQ_READ, 8'h00, 5'd3);
        offer_item(REQ_READ, 8'h00, 5'd6);

        for (int s = 0; s < SETTINGS_N; s++) begin
            case (s)
                0: begin skip_val = 16'd3;    period_val = 8'd1;   end
                1: begin skip_val = 16'd3;    period_val = 8'd255; end
                2: begin skip_val = 16'hFFFF; period_val = 8'd4;   end
                3: begin skip_val = 16'd40;   period_val = 8'd0;   end
                4: begin skip_val = 16'd0;    period_val = 8'd2;   end
                5: begin skip_val = 16'd1000; period_val = 8'd3;   end
                default: begin skip_val = 16'd0; period_val = 8'd1; end
            endcase
            write_reg(ADDR_SKIP, {16'h0, skip_val});
            write_reg(ADDR_PERIOD, {24'h0, period_val});
            case (s % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            if (s == 2) begin
                // results back up behind the hold, so the input stalls
                hold_requests++;
                repeat (30) offer_random_item();
                drain();
            end
            repeat (PER_SETTING) offer_random_item();
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
